// ===== hw/rtl/bpe_pkg.sv =====
// Shared types, constants and codes for the BMP pixel expander.
// No dependencies; every other file in hw/rtl but bpe_ram imports this package.
package bpe_pkg;

  // Image limits and palette size
  localparam int MaxWidth     = 4096;
  localparam int MaxHeight    = 4096;
  localparam int PaletteDepth = 256;

  localparam int PalAddrW = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;
  localparam int ColW     = $clog2(MaxWidth + 1);
  localparam int RowW     = $clog2(MaxHeight + 1);
  localparam int RowDiffW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  // longest padded row is 24 bpp at full width, rounded up to 4 bytes
  localparam int RbcW     = $clog2(3 * MaxWidth + 4);

  // Fixed field widths
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;
  localparam int ByteW    = 8;
  localparam int RgbW     = 24;
  localparam int AddrW    = 24;

  // Job queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Input command codes
  localparam logic CMD_PAL_WR = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    MODE_1BPP  = 2'd0,
    MODE_4BPP  = 2'd1,
    MODE_8BPP  = 2'd2,
    MODE_24BPP = 2'd3
  } mode_e;

  // 24 bpp byte order within one pixel
  typedef enum logic [1:0] {
    PH_B = 2'd0,
    PH_G = 2'd1,
    PH_R = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    JOB_PAL_WR  = 2'd0,
    JOB_PIX_IDX = 2'd1,
    JOB_PIX_RGB = 2'd2
  } job_kind_e;

  typedef struct packed {
    mode_e            mode;
    logic [ColW-1:0]  width;
    logic [RowW-1:0]  height;
  } cfg_t;

  // One queued unit of work. data: palette color, direct RGB, or the
  // source byte in [7:0]. last_k is the pixel count minus one.
  typedef struct packed {
    job_kind_e         kind;
    mode_e             mode;
    logic [2:0]        last_k;
    logic [RgbW-1:0]   data;
    logic [ByteW-1:0]  index;
    logic [AddrW-1:0]  addr;
    logic              frame_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [RgbW-1:0]  rgb;
    logic [AddrW-1:0] addr;
    logic             last;
    logic             frame_end;
  } pix_t;

endpackage

// ===== hw/rtl/bpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bpe_queue.sv =====
// Short job queue between the front (classify) and back (emit) parts.
// Depends on bpe_pkg.
module bpe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bpe_pkg::job_t      job_i,
  input  logic               pop_i,
  output bpe_pkg::job_t      job_o,
  output bpe_pkg::q_status_t status_o
);
  import bpe_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, wp_d;
  logic [QPtrW-1:0] rp_q, rp_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? QPtrW'(wp_q + 1'b1) : wp_q;
    rp_d  = pop_i ? QPtrW'(rp_q + 1'b1) : rp_q;
    cnt_d = cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  assign job_o          = mem_q[rp_q];
  assign status_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== hw/rtl/bpe_front.sv =====
// Front part: accepts items, tracks row/column/byte counters, classifies
// each byte and builds jobs (with frame buffer address) for the queue.
// Depends on bpe_pkg.
module bpe_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpe_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [bpe_pkg::ByteW-1:0] data_byte_i,
  input  logic [bpe_pkg::ByteW-1:0] entry_index_i,
  input  logic [bpe_pkg::ByteW-1:0] entry_red_i,
  input  logic [bpe_pkg::ByteW-1:0] entry_green_i,
  input  logic [bpe_pkg::ByteW-1:0] entry_blue_i,
  input  bpe_pkg::q_status_t        q_status_i,
  output logic                      q_push_o,
  output bpe_pkg::job_t             q_job_o
);
  import bpe_pkg::*;

  // counter state
  logic [ColW-1:0] column_q, column_d;
  logic [RowW-1:0] row_q, row_d;
  logic [RbcW-1:0] rbc_q, rbc_d;
  logic [15:0]     partial_q, partial_d;
  phase_e          phase_q, phase_d;

  // address stage
  logic                b_valid_q, b_valid_d;
  job_t                b_job_q, b_job_d;
  logic [RowDiffW-1:0] b_rowdiff_q, b_rowdiff_d;
  logic [ColW-1:0]     b_width_q, b_width_d;
  logic [ColW-1:0]     b_col_q, b_col_d;

  logic                accept;
  logic [RbcW-1:0]     data_bytes, padded, rbc_inc;
  logic                active, row_end;
  logic                col_lt_w, col1_lt_w, row_lt_h;
  logic [ColW:0]       remaining, col_sum, fe_sum;
  logic [3:0]          n_one, adv, n_emit;
  logic [RowW:0]       row_inc;
  logic                idx_ok, a_job_valid;
  job_t                a_job;
  logic [RowDiffW+ColW-1:0] prod;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = b_valid_q && q_status_i.full;

  // row geometry
  always_comb begin
    unique case (cfg_i.mode)
      MODE_1BPP:  data_bytes = RbcW'((RbcW'(cfg_i.width) + RbcW'(7)) >> 3);
      MODE_4BPP:  data_bytes = RbcW'((RbcW'(cfg_i.width) + RbcW'(1)) >> 1);
      MODE_8BPP:  data_bytes = RbcW'(cfg_i.width);
      MODE_24BPP: data_bytes = RbcW'((RbcW'(cfg_i.width) << 1) + RbcW'(cfg_i.width));
      default:    data_bytes = RbcW'(cfg_i.width);
    endcase
    padded  = (data_bytes + RbcW'(3)) & ~RbcW'(3);
    rbc_inc = rbc_q + RbcW'(1);
    active  = rbc_q < data_bytes;
    row_end = rbc_inc >= padded;
  end

  // pixels that this byte places
  always_comb begin
    col_lt_w  = column_q < cfg_i.width;
    col1_lt_w = ((ColW+1)'(column_q) + (ColW+1)'(1)) < (ColW+1)'(cfg_i.width);
    row_lt_h  = row_q < cfg_i.height;
    remaining = (ColW+1)'(cfg_i.width) - (ColW+1)'(column_q);
    if (!col_lt_w) begin
      n_one = 4'd0;
    end else if (remaining > (ColW+1)'(8)) begin
      n_one = 4'd8;
    end else begin
      n_one = remaining[3:0];
    end

    adv    = 4'd0;
    n_emit = 4'd0;
    if (active) begin
      unique case (cfg_i.mode)
        MODE_1BPP: begin
          adv    = n_one;
          n_emit = n_one;
        end
        MODE_4BPP: begin
          adv    = 4'd1 + 4'(col1_lt_w);
          n_emit = 4'(col_lt_w) + 4'(col1_lt_w);
        end
        MODE_8BPP: begin
          adv    = 4'd1;
          n_emit = 4'(col_lt_w);
        end
        MODE_24BPP: begin
          adv    = (phase_q == PH_R) ? 4'd1 : 4'd0;
          n_emit = (phase_q == PH_R) ? 4'(col_lt_w) : 4'd0;
        end
        default: begin
          adv    = 4'd0;
          n_emit = 4'd0;
        end
      endcase
      if (!row_lt_h) begin
        n_emit = 4'd0;
      end
    end

    col_sum = (ColW+1)'(column_q) + (ColW+1)'(adv);
    fe_sum  = (ColW+1)'(column_q) + (ColW+1)'(n_emit);
  end

  // counter update
  always_comb begin
    column_d  = column_q;
    row_d     = row_q;
    rbc_d     = rbc_q;
    partial_d = partial_q;
    phase_d   = phase_q;
    row_inc   = (RowW+1)'(row_q) + (RowW+1)'(1);
    if (accept && cmd_i == CMD_DATA) begin
      // saturate: any column at or past the widest image emits nothing
      column_d = (col_sum > (ColW+1)'(MaxWidth)) ? ColW'(MaxWidth) : ColW'(col_sum);
      if (active && cfg_i.mode == MODE_24BPP) begin
        case (phase_q)
          PH_G: begin
            partial_d = {data_byte_i, partial_q[7:0]};
            phase_d   = PH_R;
          end
          PH_R: begin
            phase_d = PH_B;
          end
          default: begin
            partial_d = 16'(data_byte_i);
            phase_d   = PH_G;
          end
        endcase
      end
      rbc_d = rbc_inc;
      if (row_end) begin
        rbc_d     = '0;
        column_d  = '0;
        phase_d   = PH_B;
        partial_d = '0;
        row_d     = (row_inc >= (RowW+1)'(cfg_i.height)) ? '0 : RowW'(row_inc);
      end
    end
  end

  // job build
  always_comb begin
    idx_ok          = (32'(entry_index_i) < 32'(PaletteDepth));
    a_job           = '0;
    a_job.mode      = cfg_i.mode;
    a_job.last_k    = 3'(n_emit - 4'd1);
    a_job.index     = entry_index_i;
    a_job.frame_end = (row_q == cfg_i.height - RowW'(1)) &&
                      (fe_sum == (ColW+1)'(cfg_i.width));
    if (cmd_i == CMD_PAL_WR) begin
      a_job.kind  = JOB_PAL_WR;
      a_job.data  = {entry_red_i, entry_green_i, entry_blue_i};
      a_job_valid = idx_ok;
    end else begin
      a_job.kind  = (cfg_i.mode == MODE_24BPP) ? JOB_PIX_RGB : JOB_PIX_IDX;
      a_job.data  = (cfg_i.mode == MODE_24BPP) ? {data_byte_i, partial_q}
                                               : RgbW'(data_byte_i);
      a_job_valid = (n_emit != 4'd0);
    end
  end

  // address stage
  always_comb begin
    b_valid_d   = b_valid_q;
    b_job_d     = b_job_q;
    b_rowdiff_d = b_rowdiff_q;
    b_width_d   = b_width_q;
    b_col_d     = b_col_q;
    if (accept) begin
      b_valid_d   = a_job_valid;
      b_job_d     = a_job;
      b_rowdiff_d = RowDiffW'(cfg_i.height - RowW'(1) - row_q);
      b_width_d   = cfg_i.width;
      b_col_d     = column_q;
    end else if (q_push_o) begin
      b_valid_d = 1'b0;
    end
  end

  assign q_push_o = b_valid_q && !q_status_i.full;
  assign prod     = (RowDiffW+ColW)'(b_rowdiff_q) * (RowDiffW+ColW)'(b_width_q);

  always_comb begin
    q_job_o      = b_job_q;
    q_job_o.addr = AddrW'(AddrW'(prod) + AddrW'(b_col_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q  <= '0;
      row_q     <= '0;
      rbc_q     <= '0;
      partial_q <= '0;
      phase_q   <= PH_B;
      b_valid_q <= 1'b0;
    end else begin
      column_q  <= column_d;
      row_q     <= row_d;
      rbc_q     <= rbc_d;
      partial_q <= partial_d;
      phase_q   <= phase_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_job_q     <= b_job_d;
    b_rowdiff_q <= b_rowdiff_d;
    b_width_q   <= b_width_d;
    b_col_q     <= b_col_d;
  end

endmodule

// ===== hw/rtl/bpe_back.sv =====
// Back part: walks queued jobs one pixel per cycle while the skid has room,
// does palette writes and lookups in the palette RAM, and buffers results
// in a 2-entry skid. Depends on bpe_pkg and bpe_ram.
module bpe_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpe_pkg::job_t             q_job_i,
  input  bpe_pkg::q_status_t        q_status_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bpe_pkg::ByteW-1:0] red_o,
  output logic [bpe_pkg::ByteW-1:0] green_o,
  output logic [bpe_pkg::ByteW-1:0] blue_o,
  output logic [bpe_pkg::AddrW-1:0] pixel_address_o,
  output logic                      last_of_run_o,
  output logic                      frame_end_o
);
  import bpe_pkg::*;

  logic [2:0]          k_q, k_d;
  logic                s1_valid_q;
  logic                s1_pal_q, s1_pal_d;
  pix_t                s1_pix_q, s1_pix_d;
  pix_t                out_mem_q [2];
  pix_t                out_push_pix;
  logic                out_wp_q, out_rp_q;
  logic [1:0]          out_cnt_q;
  logic                out_pop, room, issue;
  logic                ram_we, ram_re;
  logic [ByteW-1:0]    src_byte, pidx;
  logic                pidx_ok;
  logic [RgbW-1:0]     ram_rdata;

  assign out_valid_o = (out_cnt_q != 2'd0);
  assign out_pop     = out_valid_o && !out_stall_i;
  // an issued pixel passes the s1 register before it lands in the skid; make sure it fits
  assign room = (3'(out_cnt_q) + 3'(s1_valid_q)) <= (3'd1 + 3'(out_pop));

  // palette index of pixel k within the source byte
  always_comb begin
    src_byte = q_job_i.data[ByteW-1:0];
    unique case (q_job_i.mode)
      MODE_1BPP: pidx = ByteW'(src_byte[~k_q]);
      MODE_4BPP: pidx = k_q[0] ? ByteW'(src_byte[3:0]) : ByteW'(src_byte[7:4]);
      MODE_8BPP: pidx = src_byte;
      default:   pidx = src_byte;
    endcase
    pidx_ok = (32'(pidx) < 32'(PaletteDepth));
  end

  always_comb begin
    ram_we  = 1'b0;
    issue   = 1'b0;
    q_pop_o = 1'b0;
    k_d     = k_q;
    if (!q_status_i.empty) begin
      case (q_job_i.kind)
        JOB_PAL_WR: begin
          ram_we  = 1'b1;
          q_pop_o = 1'b1;
        end
        JOB_PIX_IDX, JOB_PIX_RGB: begin
          if (room) begin
            issue = 1'b1;
            if (k_q == q_job_i.last_k) begin
              q_pop_o = 1'b1;
              k_d     = 3'd0;
            end else begin
              k_d = k_q + 3'd1;
            end
          end
        end
        default: q_pop_o = 1'b1;
      endcase
    end
  end

  always_comb begin
    ram_re             = issue && (q_job_i.kind == JOB_PIX_IDX) && pidx_ok;
    s1_pal_d           = ram_re;
    s1_pix_d.rgb       = (q_job_i.kind == JOB_PIX_RGB) ? q_job_i.data : '0;
    s1_pix_d.addr      = AddrW'(q_job_i.addr + AddrW'(k_q));
    s1_pix_d.last      = (k_q == q_job_i.last_k);
    s1_pix_d.frame_end = (k_q == q_job_i.last_k) && q_job_i.frame_end;
  end

  bpe_ram #(
    .Width (RgbW),
    .Depth (PaletteDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_job_i.index[PalAddrW-1:0]),
    .wdata_i (q_job_i.data),
    .re_i    (ram_re),
    .raddr_i (pidx[PalAddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_push_pix     = s1_pix_q;
    out_push_pix.rgb = s1_pal_q ? ram_rdata : s1_pix_q.rgb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      s1_valid_q <= 1'b0;
      out_wp_q   <= 1'b0;
      out_rp_q   <= 1'b0;
      out_cnt_q  <= '0;
    end else begin
      k_q        <= k_d;
      s1_valid_q <= issue;
      if (s1_valid_q) begin
        out_wp_q <= ~out_wp_q;
      end
      if (out_pop) begin
        out_rp_q <= ~out_rp_q;
      end
      out_cnt_q <= out_cnt_q + 2'(s1_valid_q) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_pal_q <= s1_pal_d;
      s1_pix_q <= s1_pix_d;
    end
    if (s1_valid_q) begin
      out_mem_q[out_wp_q] <= out_push_pix;
    end
  end

  assign red_o           = out_mem_q[out_rp_q].rgb[23:16];
  assign green_o         = out_mem_q[out_rp_q].rgb[15:8];
  assign blue_o          = out_mem_q[out_rp_q].rgb[7:0];
  assign pixel_address_o = out_mem_q[out_rp_q].addr;
  assign last_of_run_o   = out_mem_q[out_rp_q].last;
  assign frame_end_o     = out_mem_q[out_rp_q].frame_end;

endmodule

// ===== hw/rtl/bmp_pixel_expander.sv =====
// BMP pixel expander top level: configuration registers, front, job queue
// and back. Depends on bpe_pkg, bpe_front, bpe_queue, bpe_back, bpe_ram.
//
// Streams the pixel-array bytes of an uncompressed BMP (1, 4, 8 or 24 bpp)
// and emits RGB pixels with their top-down frame buffer address. Palette
// entries are loaded by palette-write items (cmd = 0) on the same input
// channel; they take effect in stream order, and an entry must be written
// before a pixel uses it. Input: one item per cycle is accepted while the
// 4-entry job queue has room. Output: one pixel per cycle while the output is
// not stalled, set by the single read port of the 256 x 24 palette RAM, so a
// 1 bpp byte gives up to 8 pixels, a 4 bpp byte up to 2, and 8/24 bpp bytes
// one. A palette write is done by the back end and gives no pixel; pad
// bytes and the first two bytes of a 24 bpp pixel are not queued.
// A pixel passes the address register (loaded at the accepting edge), the
// job queue, the palette read and the output skid before it is presented.
// Configuration writes are always taken (cfg_ready_o is tied high) and
// must only be issued while the block is idle; width and height are
// clamped to 1..4096 when written. No clearing pass after reset: palette
// contents are undefined until written.
module bmp_pixel_expander (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bpe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bpe_pkg::CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [bpe_pkg::ByteW-1:0]   data_byte_i,
  input  logic [bpe_pkg::ByteW-1:0]   entry_index_i,
  input  logic [bpe_pkg::ByteW-1:0]   entry_red_i,
  input  logic [bpe_pkg::ByteW-1:0]   entry_green_i,
  input  logic [bpe_pkg::ByteW-1:0]   entry_blue_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bpe_pkg::ByteW-1:0]   red_o,
  output logic [bpe_pkg::ByteW-1:0]   green_o,
  output logic [bpe_pkg::ByteW-1:0]   blue_o,
  output logic [bpe_pkg::AddrW-1:0]   pixel_address_o,
  output logic                        last_of_run_o,
  output logic                        frame_end_o
);
  import bpe_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      cfg_we;
  q_status_t q_status;
  logic      q_push, q_pop;
  job_t      q_job_in, q_job_out;

  // --- configuration registers ---
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Dimensions are stored already clamped: zero reads as 1, too large
  // saturates to the maximum.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_PIXEL_MODE: cfg_d.mode = mode_e'(cfg_data_i[1:0]);
        CFG_IMAGE_WIDTH: begin
          if (cfg_data_i == '0) begin
            cfg_d.width = ColW'(1);
          end else if (32'(cfg_data_i) > 32'(MaxWidth)) begin
            cfg_d.width = ColW'(MaxWidth);
          end else begin
            cfg_d.width = ColW'(cfg_data_i);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data_i == '0) begin
            cfg_d.height = RowW'(1);
          end else if (32'(cfg_data_i) > 32'(MaxHeight)) begin
            cfg_d.height = RowW'(MaxHeight);
          end else begin
            cfg_d.height = RowW'(cfg_data_i);
          end
        end
        default: cfg_d = cfg_q;   // unused index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_24BPP;
      cfg_q.width  <= ColW'(1);
      cfg_q.height <= RowW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // --- front: counters, classification, address ---
  bpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .entry_index_i (entry_index_i),
    .entry_red_i   (entry_red_i),
    .entry_green_i (entry_green_i),
    .entry_blue_i  (entry_blue_i),
    .q_status_i    (q_status),
    .q_push_o      (q_push),
    .q_job_o       (q_job_in)
  );

  // --- job queue ---
  bpe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .job_i    (q_job_in),
    .pop_i    (q_pop),
    .job_o    (q_job_out),
    .status_o (q_status)
  );

  // --- back: palette RAM and pixel emission ---
  bpe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_job_i         (q_job_out),
    .q_status_i      (q_status),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .pixel_address_o (pixel_address_o),
    .last_of_run_o   (last_of_run_o),
    .frame_end_o     (frame_end_o)
  );

  // --- checks ---
  a_q_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("job queue push while full");

  a_q_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("job queue pop while empty");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_status.full)
    else $error("input stalled with room in the job queue");

  a_frame_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> last_of_run_o)
    else $error("frame end on a pixel that is not last of its byte");

endmodule

// ===== verif/bmp_pixel_expander_tb.sv =====
// Self-checking testbench for bmp_pixel_expander: directed and random byte streams,
// with palette loads and config changes, checked against a built-in pixel predictor.
// Depends on bpe_pkg and the bmp_pixel_expander RTL.
module bmp_pixel_expander_tb;
  import bpe_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 8;
  localparam int IdlePct     = 36;
  localparam int HoldCycles  = 80;       // long receiver hold-off, fills the job queue
  localparam int SettleCycles = 16;      // longer than the pipeline plus the queue depth
  localparam int RandomItems = 340;
  localparam int CycleLimit  = 300000;
  localparam int MaxPrints   = 100;

  // One input item as seen on the stream port
  typedef struct {
    logic             cmd;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] index;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } stream_item_t;

  // One emitted pixel
  typedef struct {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [AddrW-1:0] addr;
    logic             last;
    logic             frame_end;
  } pixel_t;

  // Tracks palette, config and row/column counters; queues the pixels each
  // accepted byte should produce and checks emitted pixels in order.
  class pixel_scoreboard;
    logic [RgbW-1:0]     palette [PaletteDepth];
    bit                  written [PaletteDepth];
    mode_e               mode;
    logic [CfgDataW-1:0] width_reg;
    logic [CfgDataW-1:0] height_reg;
    logic [ColW-1:0]     column;
    logic [RowW-1:0]     row;
    logic [RbcW-1:0]     row_bytes;
    logic [15:0]         partial;
    phase_e              phase;
    pixel_t              pending_pixels[$];
    pixel_t              run[$];
    int                  errors;
    int                  items;
    int                  palette_writes;
    int                  pixels;
    int                  frames;
    int                  settings;

    function new();
      mode           = MODE_24BPP;
      width_reg      = 1;
      height_reg     = 1;
      column         = '0;
      row            = '0;
      row_bytes      = '0;
      partial        = '0;
      phase          = PH_B;
      errors         = 0;
      items          = 0;
      palette_writes = 0;
      pixels         = 0;
      frames         = 0;
      settings       = 0;
    endfunction

    function int clamp_dim(input logic [CfgDataW-1:0] v, input int lim);
      if (v == 0) return 1;
      return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function void geometry(output int w, output int h, output int pad, output int data);
      int bits;
      w = clamp_dim(width_reg, MaxWidth);
      h = clamp_dim(height_reg, MaxHeight);
      case (mode)
        MODE_1BPP: bits = 1;
        MODE_4BPP: bits = 4;
        MODE_8BPP: bits = 8;
        default:   bits = 24;
      endcase
      data = (w * bits + 7) >> 3;
      pad  = (data + 3) & ~3;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
      case (idx)
        CFG_PIXEL_MODE:   mode = mode_e'(val[1:0]);
        CFG_IMAGE_WIDTH:  width_reg = val;
        CFG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function logic [RgbW-1:0] lookup(input int idx);
      if (idx >= PaletteDepth) return '0;
      return palette[idx];
    endfunction

    // Pixel at the current column, only if it lies inside the image
    function void put_pixel(input logic [RgbW-1:0] rgb, input int w, input int h);
      pixel_t p;
      if (int'(column) < w && int'(row) < h) begin
        p.red       = rgb[23:16];
        p.green     = rgb[15:8];
        p.blue      = rgb[7:0];
        p.addr      = AddrW'((h - 1 - int'(row)) * w + int'(column));
        p.last      = 1'b0;
        p.frame_end = (int'(row) == h - 1) && (int'(column) == w - 1);
        run.push_back(p);
      end
      column++;
    endfunction

    function void note_item(input stream_item_t it);
      int w, h, pad, data;
      items++;
      if (it.cmd == CMD_PAL_WR) begin
        palette[it.index] = {it.red, it.green, it.blue};
        written[it.index] = 1'b1;
        palette_writes++;
        return;
      end
      geometry(w, h, pad, data);
      run.delete();
      if (int'(row_bytes) < data) begin
        case (mode)
          MODE_1BPP: begin
            for (int i = 7; i >= 0 && int'(column) < w; i--)
              put_pixel(lookup(int'(it.data[i])), w, h);
          end
          MODE_4BPP: begin
            put_pixel(lookup(int'(it.data[7:4])), w, h);
            if (int'(column) < w) put_pixel(lookup(int'(it.data[3:0])), w, h);
          end
          MODE_8BPP: put_pixel(lookup(int'(it.data)), w, h);
          default: begin
            case (phase)
              PH_G: begin
                partial = {it.data, partial[7:0]};
                phase   = PH_R;
              end
              PH_R: begin
                put_pixel({it.data, partial}, w, h);
                phase = PH_B;
              end
              default: begin
                partial = {8'h00, it.data};
                phase   = PH_G;
              end
            endcase
          end
        endcase
      end
      row_bytes++;
      if (int'(row_bytes) >= pad) begin
        row_bytes = '0;
        column    = '0;
        phase     = PH_B;
        partial   = '0;
        row++;
        if (int'(row) >= h) row = '0;
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) begin
        if (run[i].frame_end) frames++;
        pending_pixels.push_back(run[i]);
      end
    endfunction

    // Bytes still needed to reach the end of the current frame
    function int bytes_to_frame_end();
      int w, h, pad, data, rest;
      geometry(w, h, pad, data);
      rest = (int'(row_bytes) >= pad) ? 1 : pad - int'(row_bytes);
      if (int'(row) + 1 < h) rest += (h - 1 - int'(row)) * pad;
      return rest;
    endfunction

    function int frame_bytes();
      int w, h, pad, data;
      geometry(w, h, pad, data);
      return pad * h;
    endfunction

    task report_mismatch(input string what);
      errors++;
      if (errors <= MaxPrints) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_pixel(input pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel at address %06h", got.addr));
        return;
      end
      want = pending_pixels.pop_front();
      pixels++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.addr !== want.addr || got.last !== want.last ||
          got.frame_end !== want.frame_end)
        report_mismatch($sformatf(
          "got rgb %02h%02h%02h addr %06h last %b end %b, want %02h%02h%02h %06h %b %b",
          got.red, got.green, got.blue, got.addr, got.last, got.frame_end,
          want.red, want.green, want.blue, want.addr, want.last, want.frame_end));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                cmd_i;
  logic [ByteW-1:0]    data_byte_i;
  logic [ByteW-1:0]    entry_index_i;
  logic [ByteW-1:0]    entry_red_i;
  logic [ByteW-1:0]    entry_green_i;
  logic [ByteW-1:0]    entry_blue_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ByteW-1:0]    red_o;
  logic [ByteW-1:0]    green_o;
  logic [ByteW-1:0]    blue_o;
  logic [AddrW-1:0]    pixel_address_o;
  logic                last_of_run_o;
  logic                frame_end_o;

  pixel_scoreboard sb;
  int  idle_pct = IdlePct;   // shared by sender and receiver
  bit  hold_req = 1'b0;      // asks the receiver for one long hold-off
  int  cycles = 0;

  bmp_pixel_expander DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .data_byte_i    (data_byte_i),
    .entry_index_i  (entry_index_i),
    .entry_red_i    (entry_red_i),
    .entry_green_i  (entry_green_i),
    .entry_blue_i   (entry_blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .pixel_address_o(pixel_address_o),
    .last_of_run_o  (last_of_run_o),
    .frame_end_o    (frame_end_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Watchdog: a hang or a lost pixel ends the run here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles,
               sb.pending_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  // Output monitor: pixels are taken at the rising edge when valid and not stalled.
  // out_stall_i only moves at the falling edge, so the sample is stable here.
  always @(posedge clk_i) begin
    pixel_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.red       = red_o;
      got.green     = green_o;
      got.blue      = blue_o;
      got.addr      = pixel_address_o;
      got.last      = last_of_run_o;
      got.frame_end = frame_end_o;
      sb.check_pixel(got);
    end
  end

  // Receiver back-pressure. A hold request is served as one unbroken stall whose
  // length, HoldCycles, is counted here; otherwise stall at random at idle_pct.
  initial begin : receiver
    int held;
    held        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && held < HoldCycles) begin
        out_stall_i <= 1'b1;
        held++;
      end else begin
        if (hold_req) begin
          hold_req = 1'b0;
          held     = 0;
        end
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items keep valid asserted.
  task automatic send_item(input stream_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= it.cmd;
    data_byte_i   <= it.data;
    entry_index_i <= it.index;
    entry_red_i   <= it.red;
    entry_green_i <= it.green;
    entry_blue_i  <= it.blue;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  // Pixel byte; the unused palette fields carry noise
  task automatic send_data(input logic [ByteW-1:0] b);
    stream_item_t it;
    it.cmd   = CMD_DATA;
    it.data  = b;
    it.index = $urandom_range(255);
    it.red   = $urandom_range(255);
    it.green = $urandom_range(255);
    it.blue  = $urandom_range(255);
    send_item(it);
  endtask

  task automatic send_palette(input logic [ByteW-1:0] idx, input logic [RgbW-1:0] rgb);
    stream_item_t it;
    it.cmd   = CMD_PAL_WR;
    it.data  = $urandom_range(255);
    it.index = idx;
    it.red   = rgb[23:16];
    it.green = rgb[15:8];
    it.blue  = rgb[7:0];
    send_item(it);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic set_config(input mode_e mode, input int w, input int h);
    write_reg(CFG_PIXEL_MODE, CfgDataW'(mode));
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(w));
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(h));
    cfg_valid_i <= 1'b0;
    sb.settings++;
  endtask

  // Drop valid and wait for every expected pixel; settle covers bytes that
  // give no pixel but may still be in the pipe.
  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // Random palette index among entries already loaded, below limit.
  // Keeps every lookup inside written entries.
  function automatic logic [ByteW-1:0] pick_entry(input int limit);
    int hits[$];
    for (int i = 0; i < limit; i++) if (sb.written[i]) hits.push_back(i);
    return ByteW'(hits[$urandom_range(hits.size() - 1)]);
  endfunction

  function automatic logic [ByteW-1:0] pick_data_byte();
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    hi = pick_entry(16);
    lo = pick_entry(16);
    case (sb.mode)
      MODE_4BPP: return {hi[3:0], lo[3:0]};
      MODE_8BPP: return pick_entry(PaletteDepth);
      default:   return ByteW'($urandom_range(255));
    endcase
  endfunction

  initial begin : stimulus
    int    random_sent;
    int    phase_no;
    int    count;
    mode_e mode;
    int    w;
    int    h;

    sb            = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_DATA;
    data_byte_i   = '0;
    entry_index_i = '0;
    entry_red_i   = '0;
    entry_green_i = '0;
    entry_blue_i  = '0;
    random_sent   = 0;
    phase_no      = 0;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: 24 bpp, 1x1. B, G, R then one pad byte, frame ends.
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hA5);
    send_data(8'h5A);

    // Palette: extreme colors and the extreme entry indexes
    send_palette(8'd0, 24'h000000);
    send_palette(8'd1, 24'hFFFFFF);
    send_palette(8'd15, 24'h0F1E2D);
    send_palette(8'd255, 24'hA55AC3);
    wait_drained(SettleCycles);

    // 1 bpp, 10 wide: MSB first, second byte only has two pixels left
    set_config(MODE_1BPP, 10, 1);
    send_data(8'hA5);
    send_data(8'hC0);
    send_data(8'hFF);
    send_data(8'h00);
    wait_drained(SettleCycles);

    // 4 bpp, 3 wide: high nibble first, second byte gives one pixel
    set_config(MODE_4BPP, 3, 1);
    send_data(8'hF0);
    send_data(8'h1F);
    send_data(8'h3C);
    send_data(8'hC3);
    wait_drained(SettleCycles);

    // 8 bpp: top and bottom palette entries
    set_config(MODE_8BPP, 2, 1);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'h81);
    send_data(8'h7E);
    wait_drained(SettleCycles);

    // 24 bpp with saturated height; width changed to zero in the middle of
    // a pixel, so the partial B/G is kept and the row ends early.
    set_config(MODE_24BPP, 2, 8191);
    send_data(8'h11);
    send_data(8'h22);
    wait_drained(SettleCycles);
    write_reg(CFG_IMAGE_WIDTH, '0);
    cfg_valid_i <= 1'b0;
    send_data(8'h33);
    send_data(8'h44);
    wait_drained(SettleCycles);

    // Full-size image: addresses near the top of the buffer
    set_config(MODE_1BPP, MaxWidth, MaxHeight);
    repeat (12) send_data(pick_data_byte());
    wait_drained(SettleCycles);
    // Oversized width saturates, zero height reads as 1: the counters stay mid-row
    // in row 0, which lies inside the image, so these bytes still emit pixels.
    set_config(MODE_8BPP, 8191, 0);
    repeat (4) send_data(pick_data_byte());
    wait_drained(SettleCycles);

    // Random part. Mostly whole frames (finishing whatever the counters hold),
    // some truncated streams that leave the next setting mid-frame.
    while (random_sent < RandomItems) begin
      phase_no++;
      mode = mode_e'($urandom_range(3));
      w    = $urandom_range(1, 8);
      h    = $urandom_range(1, 3);
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(9, 24);
        h = 1;
      end
      if (phase_no == 4) begin
        // Fill-up case: many pixels per byte while the receiver holds off
        mode = MODE_1BPP;
        w    = 32;
        h    = 2;
      end
      set_config(mode, w, h);

      count = sb.bytes_to_frame_end();
      if (sb.frame_bytes() <= 24) count += $urandom_range(0, 2) * sb.frame_bytes();
      if (phase_no != 4 && $urandom_range(99) < 20) count = $urandom_range(1, 10);
      if (phase_no == 4) count += 2 * sb.frame_bytes();

      // No idling on either side for a stretch, including the hold-off phase
      if (phase_no >= 2 && phase_no <= 4) idle_pct = 0;
      if (phase_no == 4) hold_req = 1'b1;

      for (int k = 0; k < count; k++) begin
        if ($urandom_range(99) < 10) begin
          send_palette($urandom_range(1) ? ByteW'($urandom_range(15))
                                         : ByteW'($urandom_range(255)),
                       RgbW'($urandom));
          random_sent++;
        end
        // Sender pauses mid-frame until every pixel is out
        if (phase_no == 6 && k == count / 2) wait_drained(0);
        send_data(pick_data_byte());
        random_sent++;
      end
      wait_drained(SettleCycles);
      idle_pct = IdlePct;
    end

    wait_drained(SettleCycles);

    if (sb.pending_pixels.size() != 0)
      sb.report_mismatch($sformatf("%0d pixels never emitted", sb.pending_pixels.size()));

    $display("ran %0d items (%0d palette loads) over %0d settings in %0d cycles",
             sb.items, sb.palette_writes, sb.settings, cycles);
    $display("checked %0d pixels across %0d completed frames, %0d mismatches",
             sb.pixels, sb.frames, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
